[design/tw_pkg.sv]
// Shared types and constants for the timing wheel timer table.
package tw_pkg;

  localparam int ID_W    = 32;
  localparam int DELAY_W = 16;
  localparam int SIZE_W  = 7;
  localparam int KIND_W  = 3;
  localparam int DIV_CNT_W = $clog2(DELAY_W);

  localparam logic [SIZE_W-1:0] SIZE_MAX = 7'd64;
  localparam logic [SIZE_W-1:0] SIZE_MIN = 7'd1;
  localparam logic [SIZE_W-1:0] SIZE_RST = 7'd60;

  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_REFRESH = 2'd1;
  localparam logic [1:0] ACT_CANCEL  = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  localparam logic [KIND_W-1:0] EV_OK        = 3'd0;
  localparam logic [KIND_W-1:0] EV_NOT_FOUND = 3'd1;
  localparam logic [KIND_W-1:0] EV_FULL      = 3'd2;
  localparam logic [KIND_W-1:0] EV_RUN       = 3'd3;
  localparam logic [KIND_W-1:0] EV_CANCELLED = 3'd4;
  localparam logic [KIND_W-1:0] EV_NONE      = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic tok;
    logic hit;
  } link_t;

  typedef struct packed {
    logic [1:0]        op;
    logic              pass2;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] per;
  } cmd_t;

  typedef struct packed {
    logic            fire;
    logic            cancelled;
    logic [ID_W-1:0] id;
  } ev_t;

endpackage

[design/tw_mod.sv]
// Bit-serial restoring modulo of the add delay by the wheel size.
module tw_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tw_pkg::DELAY_W-1:0]   dividend,
  input  logic [tw_pkg::SIZE_W-1:0]    divisor,
  output logic                         done,
  output logic [tw_pkg::SIZE_W-1:0]    result
);

  logic                          busy_r, busy_nxt;
  logic [tw_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [tw_pkg::DELAY_W-1:0]    dvd_r, dvd_nxt;
  logic [tw_pkg::SIZE_W-1:0]     dvs_r, dvs_nxt;
  logic [tw_pkg::SIZE_W-1:0]     part_r, part_nxt;
  logic [tw_pkg::SIZE_W:0]       sh;
  logic [tw_pkg::SIZE_W:0]       diff;
  logic                          ge;
  logic [tw_pkg::SIZE_W-1:0]     part_step;

  assign sh        = {part_r, dvd_r[tw_pkg::DELAY_W-1]};
  assign ge        = sh >= {1'b0, dvs_r};
  assign diff      = sh - {1'b0, dvs_r};
  assign part_step = ge ? diff[tw_pkg::SIZE_W-1:0] : sh[tw_pkg::SIZE_W-1:0];

  assign done   = busy_r && (cnt_r == {tw_pkg::DIV_CNT_W{1'b1}});
  assign result = part_step;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    part_nxt = part_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      part_nxt = '0;
    end else if (busy_r) begin
      part_nxt = part_step;
      dvd_nxt  = {dvd_r[tw_pkg::DELAY_W-2:0], 1'b0};
      cnt_nxt  = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    part_r <= part_nxt;
  end

endmodule

[design/tw_cell.sv]
// One timer slot of the chain; acts when the walking token is in it.
module tw_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  tw_pkg::cmd_t  cmd,
  input  tw_pkg::link_t link_in,
  output tw_pkg::link_t link_out,
  output tw_pkg::ev_t   ev
);

  logic                       tok_r, hit_r;
  logic                       valid_r, valid_nxt;
  logic [tw_pkg::ID_W-1:0]    key_r, key_nxt;
  logic [tw_pkg::SIZE_W-1:0]  per_r, per_nxt;
  logic [tw_pkg::SIZE_W-1:0]  rem_r, rem_nxt;
  logic                       canc_r, canc_nxt;
  logic                       act;
  logic                       match;
  logic                       claim;
  logic                       took;
  logic [tw_pkg::SIZE_W-1:0]  dec;
  logic                       expire;

  assign act    = step && tok_r;
  assign match  = valid_r && (key_r == cmd.id);
  assign claim  = !hit_r && !valid_r;
  assign dec    = (rem_r != '0) ? rem_r - 1'b1 : rem_r;
  assign expire = valid_r && (dec == '0);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    per_nxt   = per_r;
    rem_nxt   = rem_r;
    canc_nxt  = canc_r;
    took      = 1'b0;
    ev        = '0;
    case (cmd.op)
      tw_pkg::ACT_ADD: begin
        took = cmd.pass2 ? claim : match;
        if (act && took) begin
          valid_nxt = 1'b1;
          key_nxt   = cmd.id;
          per_nxt   = cmd.per;
          rem_nxt   = cmd.per;
          canc_nxt  = 1'b0;
        end
      end
      tw_pkg::ACT_REFRESH: begin
        took = match;
        if (act && took) begin
          rem_nxt = per_r;
        end
      end
      tw_pkg::ACT_CANCEL: begin
        took = match;
        if (act && took) begin
          canc_nxt = 1'b1;
        end
      end
      tw_pkg::ACT_TICK: begin
        if (act && valid_r) begin
          rem_nxt = dec;
          if (expire) begin
            valid_nxt    = 1'b0;
            ev.fire      = 1'b1;
            ev.cancelled = canc_r;
            ev.id        = key_r;
          end
        end
      end
      default: begin
        took = 1'b0;
      end
    endcase
  end

  assign link_out.tok = tok_r;
  assign link_out.hit = hit_r | took;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      hit_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (step) begin
        tok_r <= link_in.tok;
        hit_r <= link_in.hit;
      end
      valid_r <= valid_nxt;
    end
    key_r  <= key_nxt;
    per_r  <= per_nxt;
    rem_r  <= rem_nxt;
    canc_r <= canc_nxt;
  end

endmodule

[design/timing_wheel_timer_table.sv]
// Top level of the timing wheel timer table: controller, modulo unit and slot chain.
//
//  channel | direction | ports
//  in      | input     | in_valid, in_ready, in_action, in_timer_id, in_delay_ticks
//  out     | output    | out_valid, out_ready, out_event_kind, out_event_id, out_last
//  cfg     | input     | cfg_we, cfg_wdata
//
// One item at a time. A token walks the slot chain one cell per cycle when the
// output is free. Add first runs the delay modulo, then one pass, and a second
// pass to claim a free slot when the id is new. Output backpressure freezes the
// walk. Reset (rst_n, synchronous) clears all slots and sets the wheel size to 60.
module timing_wheel_timer_table #(
  parameter int MAX_TIMERS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic [tw_pkg::ID_W-1:0]     in_timer_id,
  input  logic [tw_pkg::DELAY_W-1:0]  in_delay_ticks,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tw_pkg::KIND_W-1:0]   out_event_kind,
  output logic [tw_pkg::ID_W-1:0]     out_event_id,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [tw_pkg::SIZE_W-1:0]   cfg_wdata
);

  tw_pkg::state_t state_r, state_nxt;
  tw_pkg::cmd_t   cmd_r, cmd_nxt;
  tw_pkg::link_t  link [MAX_TIMERS+1];
  tw_pkg::ev_t    cell_ev [MAX_TIMERS];
  tw_pkg::ev_t    ev_any;

  logic [tw_pkg::SIZE_W-1:0]  size_r;
  logic [tw_pkg::SIZE_W-1:0]  eff_size;
  logic [tw_pkg::SIZE_W-1:0]  div_r, div_nxt;
  logic                       inject_r, inject_nxt;
  logic                       exit_tok_r, exit_hit_r;
  logic                       pend_v_r, pend_v_nxt;
  logic [tw_pkg::KIND_W-1:0]  pend_kind_r, pend_kind_nxt;
  logic [tw_pkg::ID_W-1:0]    pend_id_r, pend_id_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [tw_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [tw_pkg::ID_W-1:0]    out_id_r, out_id_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_free;
  logic                       step;
  logic                       mod_start;
  logic                       mod_done;
  logic [tw_pkg::SIZE_W-1:0]  mod_res;

  assign eff_size = (size_r == '0) ? tw_pkg::SIZE_MIN :
                    (size_r > tw_pkg::SIZE_MAX) ? tw_pkg::SIZE_MAX : size_r;

  assign out_free = !out_valid_r || out_ready;
  assign step     = (state_r == tw_pkg::ST_WALK) && out_free;
  assign in_ready = (state_r == tw_pkg::ST_IDLE);

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_event_id   = out_id_r;
  assign out_last       = out_last_r;

  assign link[0].tok = step && inject_r;
  assign link[0].hit = 1'b0;

  for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
    tw_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (step),
      .cmd      (cmd_r),
      .link_in  (link[g]),
      .link_out (link[g+1]),
      .ev       (cell_ev[g])
    );
  end

  always_comb begin
    ev_any = '0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      ev_any = ev_any | cell_ev[i];
    end
  end

  tw_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_delay_ticks),
    .divisor  (eff_size),
    .done     (mod_done),
    .result   (mod_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    div_nxt       = div_r;
    inject_nxt    = inject_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    mod_start     = 1'b0;
    case (state_r)
      tw_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt.op    = in_action;
          cmd_nxt.id    = in_timer_id;
          cmd_nxt.pass2 = 1'b0;
          div_nxt       = eff_size;
          pend_v_nxt    = 1'b0;
          if (in_action == tw_pkg::ACT_ADD) begin
            state_nxt = tw_pkg::ST_MOD;
            mod_start = 1'b1;
          end else begin
            state_nxt  = tw_pkg::ST_WALK;
            inject_nxt = 1'b1;
          end
        end
      end
      tw_pkg::ST_MOD: begin
        if (mod_done) begin
          cmd_nxt.per = (mod_res == '0) ? div_r : mod_res;
          state_nxt   = tw_pkg::ST_WALK;
          inject_nxt  = 1'b1;
        end
      end
      tw_pkg::ST_WALK: begin
        if (step) begin
          inject_nxt = 1'b0;
          if (ev_any.fire) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_id_nxt    = pend_id_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_kind_nxt = ev_any.cancelled ? tw_pkg::EV_CANCELLED : tw_pkg::EV_RUN;
            pend_id_nxt   = ev_any.id;
          end
          if (exit_tok_r) begin
            out_last_nxt = 1'b1;
            out_id_nxt   = cmd_r.id;
            state_nxt    = tw_pkg::ST_IDLE;
            case (cmd_r.op)
              tw_pkg::ACT_TICK: begin
                out_valid_nxt = 1'b1;
                pend_v_nxt    = 1'b0;
                out_kind_nxt  = pend_v_r ? pend_kind_r : tw_pkg::EV_NONE;
                out_id_nxt    = pend_v_r ? pend_id_r : '0;
              end
              tw_pkg::ACT_ADD: begin
                if (!exit_hit_r && !cmd_r.pass2) begin
                  cmd_nxt.pass2 = 1'b1;
                  inject_nxt    = 1'b1;
                  state_nxt     = tw_pkg::ST_WALK;
                end else begin
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = exit_hit_r ? tw_pkg::EV_OK : tw_pkg::EV_FULL;
                end
              end
              default: begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = exit_hit_r ? tw_pkg::EV_OK : tw_pkg::EV_NOT_FOUND;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = tw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tw_pkg::ST_IDLE;
      size_r      <= tw_pkg::SIZE_RST;
      inject_r    <= 1'b0;
      exit_tok_r  <= 1'b0;
      exit_hit_r  <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inject_r    <= inject_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (step) begin
        exit_tok_r <= link[MAX_TIMERS].tok;
        exit_hit_r <= link[MAX_TIMERS].hit;
      end
    end
    cmd_r       <= cmd_nxt;
    div_r       <= div_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_id_r   <= pend_id_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

[tb/sv/timing_wheel_timer_table_test.sv]
// Self-checking testbench for the timing wheel timer table: directed rows, then random phases.
module timing_wheel_timer_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tw_pkg::*;

  localparam int MAX_TIMERS    = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int WATCHDOG_MAX  = 4000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              last;
  } timer_event_t;

  typedef struct packed {
    logic [1:0]         act;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] dly;
    logic               typed;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    eid;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_action;
  logic [ID_W-1:0]     in_timer_id;
  logic [DELAY_W-1:0]  in_delay_ticks;
  logic                out_valid;
  logic                out_ready;
  logic [KIND_W-1:0]   out_event_kind;
  logic [ID_W-1:0]     out_event_id;
  logic                out_last;
  logic                cfg_we;
  logic [SIZE_W-1:0]   cfg_wdata;

  // predictor state
  logic                tm_live   [MAX_TIMERS];
  logic [ID_W-1:0]     tm_key    [MAX_TIMERS];
  logic [SIZE_W-1:0]   tm_period [MAX_TIMERS];
  logic [SIZE_W-1:0]   tm_left   [MAX_TIMERS];
  logic                tm_cancel [MAX_TIMERS];
  logic [SIZE_W-1:0]   wheel_sz;

  timer_event_t step_events[$];
  timer_event_t pending_events[$];
  int           fail_count = 0;
  int           burst_left = 0;

  stim_row_t dir_rows [20] = '{
    '{ACT_TICK,    32'h0000_0000, 16'h0000, 1'b1, EV_NONE,      32'h0000_0000},
    '{ACT_REFRESH, 32'hFFFF_FFFF, 16'h0000, 1'b1, EV_NOT_FOUND, 32'hFFFF_FFFF},
    '{ACT_CANCEL,  32'h0000_0000, 16'hFFFF, 1'b1, EV_NOT_FOUND, 32'h0000_0000},
    '{ACT_ADD,     32'h0000_0000, 16'h0000, 1'b1, EV_OK,        32'h0000_0000},
    '{ACT_ADD,     32'hFFFF_FFFF, 16'hFFFF, 1'b1, EV_OK,        32'hFFFF_FFFF},
    '{ACT_ADD,     32'hA5A5_5A5A, 16'h0001, 1'b1, EV_OK,        32'hA5A5_5A5A},
    '{ACT_ADD,     32'h0000_0000, 16'h0002, 1'b1, EV_OK,        32'h0000_0000},
    '{ACT_CANCEL,  32'hA5A5_5A5A, 16'h0000, 1'b1, EV_OK,        32'hA5A5_5A5A},
    '{ACT_CANCEL,  32'hA5A5_5A5A, 16'h0000, 1'b1, EV_OK,        32'hA5A5_5A5A},
    '{ACT_TICK,    32'hFFFF_FFFF, 16'hFFFF, 1'b0, EV_OK,        32'h0000_0000},
    '{ACT_REFRESH, 32'h0000_0000, 16'h1234, 1'b1, EV_OK,        32'h0000_0000},
    '{ACT_TICK,    32'h1234_5678, 16'h5A5A, 1'b0, EV_OK,        32'h0000_0000},
    '{ACT_ADD,     32'h0000_0001, 16'd60,   1'b1, EV_OK,        32'h0000_0001},
    '{ACT_ADD,     32'h8000_0000, 16'd119,  1'b1, EV_OK,        32'h8000_0000},
    '{ACT_TICK,    32'h0000_0000, 16'h0000, 1'b0, EV_OK,        32'h0000_0000},
    '{ACT_REFRESH, 32'h0000_0000, 16'h0000, 1'b1, EV_NOT_FOUND, 32'h0000_0000},
    '{ACT_ADD,     32'h0000_0011, 16'd61,   1'b1, EV_OK,        32'h0000_0011},
    '{ACT_ADD,     32'h0000_0022, 16'd1,    1'b1, EV_OK,        32'h0000_0022},
    '{ACT_CANCEL,  32'h0000_0022, 16'h0000, 1'b1, EV_OK,        32'h0000_0022},
    '{ACT_TICK,    32'h0000_0000, 16'h0000, 1'b0, EV_OK,        32'h0000_0000}
  };

  timing_wheel_timer_table #(
    .MAX_TIMERS(MAX_TIMERS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_timer_id    (in_timer_id),
    .in_delay_ticks (in_delay_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_event_id   (out_event_id),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void note_event(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                     input logic last);
    timer_event_t ev;
    ev.kind     = kind;
    ev.id       = id;
    ev.last     = last;
    step_events = {step_events, ev};
  endfunction

  function automatic void expect_event(input timer_event_t ev);
    pending_events = {pending_events, ev};
  endfunction

  function automatic int find_timer(input logic [ID_W-1:0] id);
    for (int i = 0; i < MAX_TIMERS; i++) begin
      if (tm_live[i] && tm_key[i] == id) return i;
    end
    return -1;
  endfunction

  // Works out the events one accepted beat causes and updates the timer table.
  function automatic void timer_table_step(input logic [1:0] act, input logic [ID_W-1:0] id,
                                           input logic [DELAY_W-1:0] dly);
    int size;
    int per;
    int hit;
    step_events.delete();
    case (act)
      ACT_ADD: begin
        size = (wheel_sz == 0) ? 1 : (wheel_sz > 64) ? 64 : int'(wheel_sz);
        per  = int'(dly) % size;
        if (per == 0) per = size;
        hit = find_timer(id);
        if (hit < 0) begin
          for (int i = 0; i < MAX_TIMERS; i++) begin
            if (!tm_live[i] && hit < 0) hit = i;
          end
        end
        if (hit < 0) begin
          note_event(EV_FULL, id, 1'b1);
        end else begin
          tm_live[hit]   = 1'b1;
          tm_key[hit]    = id;
          tm_period[hit] = SIZE_W'(per);
          tm_left[hit]   = SIZE_W'(per);
          tm_cancel[hit] = 1'b0;
          note_event(EV_OK, id, 1'b1);
        end
      end
      ACT_REFRESH, ACT_CANCEL: begin
        hit = find_timer(id);
        if (hit < 0) begin
          note_event(EV_NOT_FOUND, id, 1'b1);
        end else begin
          if (act == ACT_REFRESH) tm_left[hit] = tm_period[hit];
          else tm_cancel[hit] = 1'b1;
          note_event(EV_OK, id, 1'b1);
        end
      end
      default: begin
        for (int i = 0; i < MAX_TIMERS; i++) begin
          if (tm_live[i]) begin
            if (tm_left[i] != 0) tm_left[i] = tm_left[i] - 1'b1;
            if (tm_left[i] == 0) begin
              tm_live[i] = 1'b0;
              note_event(tm_cancel[i] ? EV_CANCELLED : EV_RUN, tm_key[i], 1'b0);
            end
          end
        end
        if (step_events.size() == 0) note_event(EV_NONE, '0, 1'b1);
        else step_events[step_events.size() - 1].last = 1'b1;
      end
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id(input int reuse_pct);
    int live[$];
    foreach (tm_live[i]) begin
      if (tm_live[i]) live = {live, i};
    end
    if (live.size() != 0 && $urandom_range(0, 99) < reuse_pct)
      return tm_key[live[$urandom_range(0, live.size() - 1)]];
    if ($urandom_range(0, 1) == 1) return ID_W'($urandom_range(0, 15));
    return $urandom;
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return DELAY_W'($urandom);
      default: return DELAY_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic send_cmd(input stim_row_t row);
    timer_event_t typed_ev;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_action      <= row.act;
    in_timer_id    <= row.id;
    in_delay_ticks <= row.dly;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    timer_table_step(row.act, row.id, row.dly);
    if (row.typed) begin
      typed_ev.kind = row.kind;
      typed_ev.id   = row.eid;
      typed_ev.last = 1'b1;
      expect_event(typed_ev);
    end else begin
      foreach (step_events[i]) expect_event(step_events[i]);
    end
  endtask

  task automatic set_wheel(input logic [SIZE_W-1:0] size);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we   <= 1'b0;
    wheel_sz = size;
  endtask

  task automatic run_mix(input int count, input int add_pct, input int tick_pct);
    stim_row_t row;
    int        pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < add_pct) row.act = ACT_ADD;
      else if (pick < add_pct + tick_pct) row.act = ACT_TICK;
      else row.act = ($urandom_range(0, 1) == 1) ? ACT_REFRESH : ACT_CANCEL;
      row.id    = pick_id(row.act == ACT_ADD ? 30 : (row.act == ACT_TICK ? 0 : 80));
      row.dly   = pick_delay();
      row.typed = 1'b0;
      row.kind  = EV_OK;
      row.eid   = '0;
      send_cmd(row);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_ADD;
    in_timer_id    = '0;
    in_delay_ticks = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    wheel_sz       = SIZE_RST;
    foreach (tm_live[i]) begin
      tm_live[i]   = 1'b0;
      tm_key[i]    = '0;
      tm_period[i] = '0;
      tm_left[i]   = '0;
      tm_cancel[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) send_cmd(dir_rows[r]);

    // fill the table first so that adds hit a full table
    set_wheel(SIZE_MAX);
    run_mix(40, 70, 3);
    set_wheel('0);
    run_mix(40, 35, 35);
    set_wheel('1);
    run_mix(40, 40, 30);
    set_wheel(SIZE_MIN);
    run_mix(40, 35, 35);
    set_wheel(SIZE_W'($urandom_range(2, 63)));
    run_mix(45, 40, 30);
    set_wheel(SIZE_W'($urandom_range(0, 127)));
    run_mix(45, 40, 25);
    set_wheel(SIZE_RST);
    run_mix(47, 40, 30);

    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // receiver: stall windows of random length and mode
  initial begin
    int win;
    int mode;
    win       = 0;
    mode      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (win == 0) begin
        win  = $urandom_range(4, 48);
        mode = $urandom_range(0, 3);
      end
      win--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    timer_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        fail_count++;
        $display("%0t: beat with nothing expected: kind %0d id %h last %b",
                 $time, out_event_kind, out_event_id, out_last);
      end else begin
        want = pending_events.pop_front();
        if (out_event_kind !== want.kind) begin
          fail_count++;
          $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, out_event_kind);
        end
        if (out_event_id !== want.id) begin
          fail_count++;
          $display("%0t: event_id expected %h actual %h", $time, want.id, out_event_id);
        end
        if (out_last !== want.last) begin
          fail_count++;
          $display("%0t: last expected %b actual %b", $time, want.last, out_last);
        end
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_MAX) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog expired", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
